FILE: rtl/modulated_resonant_lowpass_unit_defines.svh
// Assertion macros for the modulated resonant lowpass checker.
// Included by files that assert; needs nothing else.
`ifndef MODULATED_RESONANT_LOWPASS_UNIT_DEFINES_SVH
`define MODULATED_RESONANT_LOWPASS_UNIT_DEFINES_SVH

// antecedent in this cycle implies consequent in this cycle
`define MRL_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("check failed");

// antecedent in this cycle implies consequent in the next cycle
`define MRL_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("check failed");

// same, also checked while reset is high
`define MRL_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("check failed");

`endif

FILE: rtl/mrl_pkg.sv
// Shared types and constants of the modulated resonant lowpass.
// No dependencies.
`default_nettype none

package mrl_pkg;

  localparam int MUL_W = 40;
  typedef logic signed [MUL_W-1:0] w_t;
  typedef logic signed [2*MUL_W-1:0] prod_t;

  localparam w_t Q_ONE = 40'sd16777216;
  localparam w_t K_1P1 = 40'sd18454938;
  localparam w_t S_C1  = 40'sd26353589;
  localparam w_t S_C3  = 40'sd10764152;
  localparam w_t S_C5  = 40'sd1187765;
  localparam w_t SH_CENTER = 40'sd1000;

  localparam logic [31:0] NOISE_SEED = 32'hACE1ACE1;
  localparam logic [31:0] NOISE_MASK = 32'h80200003;
  localparam logic [11:0] REM_DIV    = 12'd2000;
  localparam logic [25:0] PHASE_ONE  = 26'd16777216;

  localparam int CFG_W = 27;

  typedef enum logic [2:0] {
    REG_BASE_CUTOFF  = 3'd0,
    REG_RESONANCE    = 3'd1,
    REG_INPUT_GAIN   = 3'd2,
    REG_ENV_DEPTH    = 3'd3,
    REG_ATTACK_COEF  = 3'd4,
    REG_RELEASE_COEF = 3'd5,
    REG_LFO_DEPTH    = 3'd6,
    REG_LFO_STEP     = 3'd7
  } reg_idx_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_ENV,
    ST_LFO_SEL,
    ST_SINE_X2,
    ST_SINE_P1,
    ST_SINE_P2,
    ST_SINE_P3,
    ST_LFO_VAL,
    ST_SH_REM,
    ST_SH_VAL,
    ST_CUT,
    ST_T1,
    ST_T2,
    ST_T3,
    ST_IN1,
    ST_IN2,
    ST_BAND,
    ST_LOW,
    ST_OUT
  } state_t;

  function automatic logic signed [31:0] sat32(input w_t v);
    if (v > 40'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -40'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/mrl_channels.sv
// Handshake channels of the modulated resonant lowpass.
// Independent of the package.
`default_nettype none

interface mrl_in_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] left_sample;
  logic signed [23:0] right_sample;
  modport source (output valid, left_sample, right_sample, input ready);
  modport sink   (input valid, left_sample, right_sample, output ready);
endinterface

interface mrl_out_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] mono_out;
  modport source (output valid, mono_out, input ready);
  modport sink   (input valid, mono_out, output ready);
endinterface

`default_nettype wire

FILE: rtl/mrl_mul.sv
// Bit-serial signed multiplier, one multiplier bit per cycle.
// Depends on mrl_pkg.
`default_nettype none

module mrl_mul import mrl_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire w_t   a,
  input  wire w_t   b,
  output logic      done,
  output prod_t     prod
);

  localparam int CNT_W = $clog2(MUL_W);

  logic                    busy;
  logic [CNT_W-1:0]        cnt;
  w_t                      a_reg;
  logic signed [MUL_W:0]   acc_hi;
  logic [MUL_W-1:0]        acc_lo;
  logic                    last;
  logic signed [MUL_W:0]   addend;
  logic signed [MUL_W:0]   sum;

  always_comb begin
    last = (cnt == CNT_W'(MUL_W - 1));
    if (!acc_lo[0]) begin
      addend = '0;
    end else if (last) begin
      addend = -(MUL_W+1)'(a_reg);
    end else begin
      addend = (MUL_W+1)'(a_reg);
    end
    sum = acc_hi + addend;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy   <= 1'b1;
        cnt    <= '0;
        a_reg  <= a;
        acc_hi <= '0;
        acc_lo <= b;
      end else if (busy) begin
        // shift the partial product right one place per step
        acc_hi <= {sum[MUL_W], sum[MUL_W:1]};
        acc_lo <= {sum[0], acc_lo[MUL_W-1:1]};
        cnt    <= cnt + 1'b1;
        if (last) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign prod = {acc_hi[MUL_W-1:0], acc_lo};

endmodule

`default_nettype wire

FILE: rtl/mrl_urem.sv
// Bit-serial remainder of a 32-bit word by the sample-and-hold modulus.
// Depends on mrl_pkg.
`default_nettype none

module mrl_urem import mrl_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [31:0] value,
  output logic             done,
  output logic [10:0]      rem
);

  logic        busy;
  logic [4:0]  cnt;
  logic [31:0] sh;
  logic [11:0] trial;
  logic [11:0] reduced;

  always_comb begin
    trial   = {rem, sh[31]};
    reduced = (trial >= REM_DIV) ? trial - REM_DIV : trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        sh   <= value;
        rem  <= '0;
      end else if (busy) begin
        rem <= reduced[10:0];
        sh  <= {sh[30:0], 1'b0};
        cnt <= cnt + 1'b1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/modulated_resonant_lowpass_unit.sv
// Modulated resonant lowpass: sequencer, state and datapath around the
// shared bit-serial multiplier and remainder units. Depends on mrl_pkg,
// mrl_channels, mrl_mul and mrl_urem.
//
// Use: each beat on the samples channel carries a stereo pair; each beat on
// the result channel carries one filtered mono sample, one per input beat,
// in order. Registers are written through cfg_we/cfg_index/cfg_data; the
// user must write them only while the block is idle, which the block itself
// does not enforce. One item at a time: every multiply goes through the one
// bit-serial multiplier. An item needs 14 multiplies with the sine LFO, 9
// with a held sample-and-hold value, and 10 plus a remainder pass when a new
// value is drawn.
// The input is taken again as soon as the sequencer is back in idle, even
// while the previous result still sits in the output register; a stalled
// receiver holds the result and blocks only the next output load.
// Reset (synchronous, active high) restores the register defaults, clears
// the filter, envelope and LFO state and seeds the noise register.
`default_nettype none

module modulated_resonant_lowpass_unit import mrl_pkg::*; #(
  parameter int FILTER_MAX      = 16609443,
  parameter int TRIGGER_LEVEL   = 0,
  parameter int SINE_TABLE_BITS = 10
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic [2:0]       cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data,
  mrl_in_if.sink                samples,
  mrl_out_if.source             result
);

  localparam int N = SINE_TABLE_BITS;
  localparam w_t F_MAX = w_t'(FILTER_MAX);

  // configuration
  logic signed [25:0] base_cutoff;
  logic [23:0]        resonance;
  logic [26:0]        input_gain;
  logic signed [24:0] env_depth;
  logic [24:0]        attack_coef;
  logic [24:0]        release_coef;
  logic signed [24:0] lfo_depth;
  logic [24:0]        lfo_step;

  // state
  state_t             state, state_next;
  logic               issued;
  logic signed [25:0] a_reg;
  logic [25:0]        level;
  logic [30:0]        envelope;
  logic signed [31:0] lfo_value;
  logic [25:0]        lfo_phase;
  logic signed [31:0] band_state;
  logic signed [31:0] low_state;
  logic               above_threshold;
  logic [31:0]        noise_register;
  logic [10:0]        rem;
  logic [24:0]        f;
  w_t                 x2;
  w_t                 tq;
  w_t                 inner;
  logic               out_valid;
  logic signed [23:0] mono_out;

  // units
  logic        mul_start, mul_done, rem_start, rem_done;
  w_t          mul_a, mul_b;
  prod_t       mul_prod;
  logic [10:0] rem_val;

  mrl_mul u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .a(mul_a), .b(mul_b),
    .done(mul_done), .prod(mul_prod)
  );

  mrl_urem u_urem (
    .clk(clk), .rst(rst), .start(rem_start), .value(noise_register),
    .done(rem_done), .rem(rem_val)
  );

  // datapath helpers
  w_t                 r_q, r_raw;
  logic               hold, level_gt, sh_due, load_out;
  logic [N-1:0]       idx;
  logic [1:0]         quad;
  w_t                 x;
  w_t                 env_cand, f_sum, diff_bl;
  logic [30:0]        env_new;
  logic [31:0]        noise_next;
  logic signed [30:0] low_half;
  logic signed [25:0] a_new;
  logic signed [24:0] lr_sum;

  always_comb begin
    r_q      = mul_prod[MUL_W+23:24];
    r_raw    = mul_prod[MUL_W-1:0];
    hold     = lfo_depth < 0;
    level_gt = {5'b0, level} > envelope;
    sh_due   = lfo_phase > PHASE_ONE;
    idx      = lfo_phase[23 -: N];
    quad     = idx[N-1 -: 2];
    x        = w_t'({idx[N-3:0], {(26-N){1'b0}}});
    if (quad[0]) x = Q_ONE - x;
    if (TRIGGER_LEVEL == 0) begin
      env_cand = level_gt ? w_t'(envelope) + r_q : r_q;
    end else begin
      env_cand = level_gt ? w_t'(level) : r_q;
    end
    if (env_cand < 0) begin
      env_new = '0;
    end else if (env_cand > 40'sd2147483647) begin
      env_new = '1;
    end else begin
      env_new = env_cand[30:0];
    end
    f_sum   = w_t'(base_cutoff) + r_q + w_t'(lfo_value);
    diff_bl = w_t'(band_state) - w_t'(low_state);
    noise_next = noise_register[0] ? ({1'b0, noise_register[31:1]} ^ NOISE_MASK)
                                   : {1'b0, noise_register[31:1]};
    low_half = low_state[31:1];
    lr_sum   = 25'(samples.left_sample) + 25'(samples.right_sample);
    a_new    = {lr_sum, 1'b0};
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:    if (samples.valid) state_next = ST_ENV;
      ST_ENV:     if (mul_done) state_next = ST_LFO_SEL;
      ST_LFO_SEL: begin
        if (!hold) state_next = ST_SINE_X2;
        else if (sh_due) state_next = ST_SH_REM;
        else state_next = ST_CUT;
      end
      ST_SINE_X2: if (mul_done) state_next = ST_SINE_P1;
      ST_SINE_P1: if (mul_done) state_next = ST_SINE_P2;
      ST_SINE_P2: if (mul_done) state_next = ST_SINE_P3;
      ST_SINE_P3: if (mul_done) state_next = ST_LFO_VAL;
      ST_LFO_VAL: if (mul_done) state_next = ST_CUT;
      ST_SH_REM:  if (rem_done) state_next = ST_SH_VAL;
      ST_SH_VAL:  if (mul_done) state_next = ST_CUT;
      ST_CUT:     if (mul_done) state_next = ST_T1;
      ST_T1:      if (mul_done) state_next = ST_T2;
      ST_T2:      if (mul_done) state_next = ST_T3;
      ST_T3:      if (mul_done) state_next = ST_IN1;
      ST_IN1:     if (mul_done) state_next = ST_IN2;
      ST_IN2:     if (mul_done) state_next = ST_BAND;
      ST_BAND:    if (mul_done) state_next = ST_LOW;
      ST_LOW:     if (mul_done) state_next = ST_OUT;
      ST_OUT:     if (load_out) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    mul_start = 1'b0;
    rem_start = 1'b0;
    samples.ready = (state == ST_IDLE);
    load_out  = (state == ST_OUT) && (!out_valid || result.ready);
    case (state)
      ST_ENV: begin
        if (level_gt) begin
          mul_a = w_t'(attack_coef);
          mul_b = w_t'(level) - w_t'(envelope);
        end else begin
          mul_a = w_t'(envelope);
          mul_b = w_t'(release_coef);
        end
      end
      ST_SINE_X2: begin mul_a = x;                mul_b = x;             end
      ST_SINE_P1: begin mul_a = S_C5;             mul_b = x2;            end
      ST_SINE_P2: begin mul_a = tq;               mul_b = x2;            end
      ST_SINE_P3: begin mul_a = tq;               mul_b = x;             end
      ST_LFO_VAL: begin mul_a = w_t'(lfo_depth);  mul_b = tq;            end
      ST_SH_VAL:  begin
        mul_a = -w_t'(lfo_depth);
        mul_b = w_t'(rem) - SH_CENTER;
      end
      ST_CUT:     begin mul_a = w_t'(env_depth);  mul_b = w_t'(envelope); end
      ST_T1:      begin mul_a = K_1P1;            mul_b = w_t'(f);       end
      ST_T2:      begin mul_a = w_t'(f);          mul_b = tq;            end
      ST_T3:      begin mul_a = w_t'(resonance);  mul_b = tq;            end
      ST_IN1:     begin mul_a = w_t'(input_gain); mul_b = w_t'(a_reg);   end
      ST_IN2:     begin mul_a = tq;               mul_b = diff_bl;       end
      ST_BAND:    begin mul_a = w_t'(f);          mul_b = inner;         end
      ST_LOW:     begin mul_a = w_t'(f);          mul_b = diff_bl;       end
      default: ;
    endcase
    case (state)
      ST_IDLE, ST_LFO_SEL, ST_OUT: ;
      ST_SH_REM: rem_start = !issued;
      default:   mul_start = !issued;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      issued          <= 1'b0;
      out_valid       <= 1'b0;
      base_cutoff     <= 26'sd2516582;
      resonance       <= 24'd14000000;
      input_gain      <= 27'd8388608;
      env_depth       <= 25'sd1342177;
      attack_coef     <= 25'd16395300;
      release_coef    <= 25'd16776000;
      lfo_depth       <= 25'sd1342177;
      lfo_step        <= 25'd1000;
      envelope        <= '0;
      lfo_value       <= '0;
      lfo_phase       <= '0;
      band_state      <= '0;
      low_state       <= '0;
      above_threshold <= 1'b0;
      noise_register  <= NOISE_SEED;
    end else begin
      state <= state_next;
      if (mul_start || rem_start) issued <= 1'b1;
      else if (mul_done || rem_done) issued <= 1'b0;

      if (cfg_we) begin
        case (reg_idx_t'(cfg_index))
          REG_BASE_CUTOFF:  base_cutoff  <= cfg_data[25:0];
          REG_RESONANCE:    resonance    <= cfg_data[23:0];
          REG_INPUT_GAIN:   input_gain   <= cfg_data[26:0];
          REG_ENV_DEPTH:    env_depth    <= cfg_data[24:0];
          REG_ATTACK_COEF:  attack_coef  <= cfg_data[24:0];
          REG_RELEASE_COEF: release_coef <= cfg_data[24:0];
          REG_LFO_DEPTH:    lfo_depth    <= cfg_data[24:0];
          REG_LFO_STEP:     lfo_step     <= cfg_data[24:0];
          default: ;
        endcase
      end

      if (state == ST_IDLE && samples.valid) begin
        a_reg <= a_new;
        level <= (a_new < 0) ? 26'(-a_new) : a_new;
      end

      if (mul_done) begin
        case (state)
          ST_ENV: begin
            envelope <= env_new;
            if (TRIGGER_LEVEL != 0) begin
              // retrigger the sample-and-hold on a rising crossing
              if (32'(env_new) > 32'(TRIGGER_LEVEL) && !above_threshold && hold)
                lfo_phase <= 26'(2 * 16777216);
              above_threshold <= 32'(env_new) > 32'(TRIGGER_LEVEL);
            end
          end
          ST_SINE_X2: x2 <= r_q;
          ST_SINE_P1: tq <= S_C3 - r_q;
          ST_SINE_P2: tq <= S_C1 - r_q;
          ST_SINE_P3: tq <= quad[1] ? -r_q : r_q;
          ST_LFO_VAL: begin
            lfo_value <= r_q[31:0];
            lfo_phase <= {2'b00, lfo_phase[23:0] + lfo_step[23:0]};
          end
          ST_SH_VAL: begin
            lfo_value <= sat32(r_raw);
            lfo_phase <= 26'(lfo_step);
          end
          ST_CUT: begin
            if (f_sum < 0) f <= '0;
            else if (f_sum > F_MAX) f <= 25'(FILTER_MAX);
            else f <= f_sum[24:0];
          end
          ST_T1:   tq <= Q_ONE + r_q;
          ST_T2:   tq <= Q_ONE + r_q;
          ST_T3:   tq <= w_t'(resonance) + r_q;
          ST_IN1:  inner <= r_q - w_t'(band_state);
          ST_IN2:  inner <= inner + r_q;
          ST_BAND: band_state <= sat32(w_t'(band_state) + r_q);
          ST_LOW:  low_state <= sat32(w_t'(low_state) + r_q);
          default: ;
        endcase
      end

      if (state == ST_LFO_SEL && hold) begin
        if (sh_due) noise_register <= noise_next;
        else lfo_phase <= 26'(lfo_phase + 26'(lfo_step));
      end
      if (state == ST_SH_REM && rem_done) rem <= rem_val;

      if (load_out) begin
        out_valid <= 1'b1;
        if (low_half > 31'sd8388607) mono_out <= 24'sh7FFFFF;
        else if (low_half < -31'sd8388608) mono_out <= 24'sh800000;
        else mono_out <= low_half[23:0];
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign result.valid    = out_valid;
  assign result.mono_out = mono_out;

endmodule

`default_nettype wire

FILE: rtl/mrl_checker.sv
// Port-level checks of the modulated resonant lowpass and their binding.
// Depends on modulated_resonant_lowpass_unit_defines.svh.
`default_nettype none
`include "modulated_resonant_lowpass_unit_defines.svh"

module mrl_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [23:0] mono_out
);

  `MRL_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)
  `MRL_ASSERT_NEXT(a_out_stable, clk, rst, out_valid && !out_ready, $stable(mono_out))
  `MRL_ASSERT_NEXT_ALWAYS(a_rst_empty, clk, rst, !out_valid)
  `MRL_ASSERT_NEXT(a_busy_after_take, clk, rst, in_valid && in_ready, !in_ready)
  // a fresh result never appears right after a beat is taken
  `MRL_ASSERT_NEXT(a_no_early_out, clk, rst, in_valid && in_ready, !$rose(out_valid))

endmodule

bind modulated_resonant_lowpass_unit mrl_checker u_mrl_checker (
  .clk(clk),
  .rst(rst),
  .in_valid(samples.valid),
  .in_ready(samples.ready),
  .out_valid(result.valid),
  .out_ready(result.ready),
  .mono_out(result.mono_out)
);

`default_nettype wire
